// ===== rtl/fci_pkg.sv =====
package fci_pkg;

	localparam int unsigned FlashBytes = 524288;
	localparam int unsigned AddrW      = 19;
	localparam int unsigned LenW       = 20;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [AddrW-1:0] SECTOR1_BASE = 19'h60000;

	localparam logic [11:0] ADDR_UNLOCK1 = 12'hAAA;
	localparam logic [11:0] ADDR_UNLOCK2 = 12'h555;

	localparam logic [7:0] CMD_UNLOCK1      = 8'hAA;
	localparam logic [7:0] CMD_UNLOCK2      = 8'h55;
	localparam logic [7:0] CMD_AUTOSEL      = 8'h90;
	localparam logic [7:0] CMD_PROG         = 8'hA0;
	localparam logic [7:0] CMD_ERASE        = 8'h80;
	localparam logic [7:0] CMD_FAST         = 8'h20;
	localparam logic [7:0] CMD_RESET        = 8'hF0;
	localparam logic [7:0] CMD_CHIP_ERASE   = 8'h10;
	localparam logic [7:0] CMD_SECTOR_ERASE = 8'h30;

	localparam logic [7:0] ID_MANUFACTURER = 8'h04;
	localparam logic [7:0] ID_DEVICE       = 8'h0C;
	localparam logic [7:0] ID_PROTECT      = 8'h00;
	localparam logic [7:0] STATUS_READY    = 8'h04;

	typedef enum logic [5:0] {
		MODE_READ     = 6'b000001,
		MODE_AUTOSEL  = 6'b000010,
		MODE_PROG     = 6'b000100,
		MODE_ERASE    = 6'b001000,
		MODE_FAST     = 6'b010000,
		MODE_FASTPROG = 6'b100000
	} mode_t;

	typedef enum logic [2:0] {
		UNLOCK_IDLE = 3'b001,
		UNLOCK_AA   = 3'b010,
		UNLOCK_55   = 3'b100
	} unlock_t;

	typedef struct packed {
		logic             op;
		logic [AddrW-1:0] flash_addr;
		logic [7:0]       write_value;
		logic [7:0]       array_byte;
	} req_t;

	typedef struct packed {
		logic [7:0]       read_data;
		logic             program_strobe;
		logic [7:0]       program_data;
		logic             erase_strobe;
		logic [AddrW-1:0] erase_base;
		logic [LenW-1:0]  erase_length;
		logic             flash_modified;
	} rsp_t;

	typedef struct packed {
		mode_t [1:0] mode;
		unlock_t     unlock;
		logic        modified;
	} state_t;

	typedef struct packed {
		logic [AddrW-1:0] base;
		logic [LenW-1:0]  len;
	} region_t;

endpackage

// ===== rtl/fci_if.sv =====
interface fci_req_if;
	logic          valid;
	logic          ready;
	fci_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fci_rsp_if;
	logic          valid;
	logic          ready;
	fci_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/fci_decode.sv =====
module fci_decode (
	input  fci_pkg::req_t   item,
	input  fci_pkg::state_t st,
	output fci_pkg::rsp_t   res,
	output fci_pkg::state_t nxt
);
	import fci_pkg::*;

	function automatic region_t sector_region(input logic [AddrW-1:0] a);
		region_t r;
		if (a < 19'h60000) begin
			r.base = {a[18:16], 16'h0000};
			r.len  = 20'h10000;
		end else if (a < 19'h64000) begin
			r.base = 19'h60000;
			r.len  = 20'h04000;
		end else if (a < 19'h6C000) begin
			r.base = 19'h64000;
			r.len  = 20'h08000;
		end else if (a < 19'h74000) begin
			r.base = {a[18:13], 13'h0000};
			r.len  = 20'h02000;
		end else if (a < 19'h7C000) begin
			r.base = 19'h74000;
			r.len  = 20'h08000;
		end else begin
			r.base = 19'h7C000;
			r.len  = 20'h04000;
		end
		return r;
	endfunction

	logic       s;
	mode_t      m;
	logic [3:0] id_key;
	logic [7:0] v;
	logic [11:0] low_addr;
	region_t    reg_sel;

	assign s        = (item.flash_addr >= SECTOR1_BASE);
	assign m        = st.mode[s];
	assign id_key   = {item.flash_addr[7], item.flash_addr[2:0]};
	assign v        = item.write_value;
	assign low_addr = item.flash_addr[11:0];
	assign reg_sel  = sector_region(item.flash_addr);

	always_comb begin
		res = '0;
		nxt = st;
		if (item.op == OP_READ) begin
			res.read_data = item.array_byte;
			unique case (m)
				MODE_FAST: begin
					res.read_data = (item.array_byte & 8'h80) | STATUS_READY;
				end
				MODE_AUTOSEL: begin
					if (id_key == 4'b0000) res.read_data = ID_MANUFACTURER;
					else if (id_key == 4'b0010) res.read_data = ID_DEVICE;
					else if (id_key == 4'b0100) res.read_data = ID_PROTECT;
				end
				default: begin
				end
			endcase
		end else begin
			unique case (m)
				MODE_PROG, MODE_FASTPROG: begin
					nxt.modified       = 1'b1;
					res.program_strobe = 1'b1;
					res.program_data   = item.array_byte & v;
					nxt.mode[s]        = (m == MODE_PROG) ? MODE_READ : MODE_FAST;
				end
				MODE_FAST: begin
					if (v == CMD_PROG) nxt.mode[s] = MODE_FASTPROG;
					else if (v == CMD_AUTOSEL) nxt.mode[s] = MODE_READ;
				end
				default: begin
					if (v == CMD_RESET) nxt.mode[s] = MODE_READ;
					if (st.unlock == UNLOCK_IDLE && v == CMD_UNLOCK1 &&
					    low_addr == ADDR_UNLOCK1) begin
						nxt.unlock = UNLOCK_AA;
					end else if (st.unlock == UNLOCK_AA) begin
						nxt.unlock = (v == CMD_UNLOCK2 && low_addr == ADDR_UNLOCK2) ?
							UNLOCK_55 : UNLOCK_IDLE;
					end else if (st.unlock == UNLOCK_55) begin
						if (nxt.mode[s] == MODE_ERASE) begin
							if (v == CMD_CHIP_ERASE) begin
								nxt.modified     = 1'b1;
								res.erase_strobe = 1'b1;
								res.erase_base   = '0;
								res.erase_length = LenW'(FlashBytes);
							end else if (v == CMD_SECTOR_ERASE) begin
								nxt.modified     = 1'b1;
								res.erase_strobe = 1'b1;
								res.erase_base   = reg_sel.base;
								res.erase_length = reg_sel.len;
							end
							nxt.mode[s] = MODE_READ;
						end else begin
							if (v == CMD_AUTOSEL) nxt.mode[s] = MODE_AUTOSEL;
							else if (v == CMD_PROG) nxt.mode[s] = MODE_PROG;
							else if (v == CMD_ERASE) nxt.mode[s] = MODE_ERASE;
							else if (v == CMD_FAST) nxt.mode[s] = MODE_FAST;
						end
						nxt.unlock = UNLOCK_IDLE;
						// only one sector may be busy at a time
						if (nxt.mode[0] != MODE_READ && nxt.mode[1] != MODE_READ)
							nxt.mode[~s] = MODE_READ;
					end
				end
			endcase
		end
		res.flash_modified = nxt.modified;
	end

endmodule

// ===== rtl/flash_command_interface.sv =====
// Command front end of a two-sector 512 KiB flash. Every bus access enters as one
// transaction on req and yields exactly one transaction on rsp, in order. A new
// access is taken every cycle while rsp is not back-pressured. An access passes
// the input register, then the result register, which offers its result on rsp;
// the per-sector mode, unlock stage and modified flag are updated as the access
// moves into the result register. rsp back-pressure stalls the input register, then req.
module flash_command_interface (
	input logic       clk,
	input logic       arst_n,
	fci_req_if.sink   req,
	fci_rsp_if.source rsp
);
	import fci_pkg::*;

	logic   valid_s1;
	req_t   item_s1;
	logic   out_valid_q;
	rsp_t   result_q;
	state_t state_q;
	rsp_t   res;
	state_t nxt;
	logic   advance;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = result_q;

	fci_decode u_decode (
		.item (item_s1),
		.st   (state_q),
		.res  (res),
		.nxt  (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '{mode: '{MODE_READ, MODE_READ}, unlock: UNLOCK_IDLE,
			                 modified: 1'b0};
		end else begin
			if (req.valid && req.ready) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) begin
				out_valid_q <= 1'b1;
				state_q     <= nxt;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) item_s1 <= req.data;
		if (advance) result_q <= res;
	end

endmodule

// ===== rtl/fci_chk.sv =====
module fci_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input fci_pkg::rsp_t rsp_data
);
	import fci_pkg::*;

	// stalled result transaction stays up
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped under stall");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_data.program_strobe && rsp_data.erase_strobe))
		else $error("program and erase in one transaction");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.program_strobe || rsp_data.erase_strobe) |->
			rsp_data.flash_modified)
		else $error("modified flag not set on array change");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.erase_strobe |->
			rsp_data.erase_base == '0 && rsp_data.erase_length == '0)
		else $error("erase region without erase strobe");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.program_strobe |-> rsp_data.program_data == '0)
		else $error("program data without program strobe");

endmodule

bind flash_command_interface fci_chk u_fci_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
